>>> src/sle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int STORE_DEPTH   = 64;
    localparam int LINE_LIMIT    = (LINE_CAPACITY < STORE_DEPTH) ? LINE_CAPACITY : STORE_DEPTH;

    localparam logic [5:0] FILL_MAX = 6'(LINE_LIMIT - 1);

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_BELL  = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_ERASE,
        OP_LINE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic       echo_en;
    } t_cmd;

    typedef struct packed {
        logic [1:0] echo_count;
        logic [7:0] echo_first;
        logic [7:0] echo_second;
        logic [7:0] echo_third;
        logic [7:0] line_byte;
        logic       line_valid;
        logic       line_done;
        logic [5:0] line_length;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

>>> src/serial_line_editor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_editor
// Line editor for a serial link: stores bytes, handles erase, echoes edits
// and reads out the completed line on CR.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | i_rx_byte
//  result   | empty / pop        | o_echo_*, o_line_*, o_last
//  config   | i_cfg_we           | i_cfg_data (echo enable)
//
// Requests are queued, then registered; one is taken per cycle while the
// queue has room. A CR with n stored bytes gives n+1 results: the echo,
// then the n bytes from the line store, one per cycle unless the output
// stalls. Reset is synchronous and needs no clearing pass. Either side may
// stall freely; the two-entry queue and the result register decouple them.
// ----------------------------------------------------------------------------
module serial_line_editor import sle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_echo_count,
    output logic [7:0]      o_echo_first,
    output logic [7:0]      o_echo_second,
    output logic [7:0]      o_echo_third,
    output logic [7:0]      o_line_byte,
    output logic            o_line_valid,
    output logic            o_line_done,
    output logic [5:0]      o_line_length,
    output logic            o_last
);

    t_cmd    f_cmd;
    t_cmd    q_cmd;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_result res;

    sle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_cmd      (f_cmd)
    );

    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    sle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_res     (res)
    );

    assign o_echo_count  = res.echo_count;
    assign o_echo_first  = res.echo_first;
    assign o_echo_second = res.echo_second;
    assign o_echo_third  = res.echo_third;
    assign o_line_byte   = res.line_byte;
    assign o_line_valid  = res.line_valid;
    assign o_line_done   = res.line_done;
    assign o_line_length = res.line_length;
    assign o_last        = res.last;

endmodule
`default_nettype wire

>>> src/sle_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_front
// Holds the echo setting, decodes each received byte into an editor command.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_cmd            o_cmd
);

    logic r_echo_en;
    t_op  op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_echo_en <= i_cfg_data;
        end
    end

    always_comb begin
        unique case (i_rx_byte) inside
            CH_CR:          op = OP_LINE;
            CH_NUL, CH_LF:  op = OP_NONE;
            CH_BS, CH_DEL:  op = OP_ERASE;
            default:        op = OP_STORE;
        endcase
    end

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;
    // fields in struct order: op, rx_byte, echo_en
    assign o_cmd    = {op, i_rx_byte, r_echo_en};

endmodule
`default_nettype wire

>>> src/sle_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_queue
// Two-entry command queue between the decoder and the executor.
// ----------------------------------------------------------------------------
module sle_queue import sle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

>>> src/sle_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_back
// Executes editor commands: line store, fill count, echo and line readout,
// with a registered result stage.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_cmd i_cmd,
    output logic      o_q_pop,
    output logic      empty,
    input  wire logic pop,
    output t_result   o_res
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_idx, n_idx;
    logic [5:0] r_len, n_len;
    t_result    r_out, n_out;
    logic       r_out_valid, n_out_valid;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;
    logic       wr_en;
    logic       ld_ok;
    logic       fin;

    assign ld_ok = !r_out_valid || pop;
    assign fin   = (r_idx + 6'd1 == r_len);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && ld_ok) begin
                    o_q_pop     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    unique case (i_cmd.op)
                        OP_STORE: begin
                            if (r_fill < FILL_MAX) begin
                                wr_en            = 1'b1;
                                n_fill           = r_fill + 6'd1;
                                n_out.echo_first = i_cmd.echo_en ? i_cmd.rx_byte : 8'd0;
                            end else begin
                                n_out.echo_first = i_cmd.echo_en ? CH_BELL : 8'd0;
                            end
                            n_out.echo_count = i_cmd.echo_en ? 2'd1 : 2'd0;
                        end
                        OP_ERASE: begin
                            if (r_fill != 6'd0) begin
                                n_fill = r_fill - 6'd1;
                                if (i_cmd.echo_en) begin
                                    n_out.echo_count  = 2'd3;
                                    n_out.echo_first  = CH_BS;
                                    n_out.echo_second = CH_SPACE;
                                    n_out.echo_third  = CH_BS;
                                end
                            end
                        end
                        OP_LINE: begin
                            if (i_cmd.echo_en) begin
                                n_out.echo_count  = 2'd2;
                                n_out.echo_first  = CH_CR;
                                n_out.echo_second = CH_LF;
                            end
                            n_len  = r_fill;
                            n_fill = 6'd0;
                            n_idx  = 6'd0;
                            if (r_fill == 6'd0) begin
                                n_out.line_done = 1'b1;
                            end else begin
                                n_out.last = 1'b0;
                                n_state    = ST_READ;
                            end
                        end
                        default: begin
                            // dropped byte: bare terminating request
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (ld_ok) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.line_byte  = r_rd_data;
                    n_out.line_valid = 1'b1;
                    if (fin) begin
                        n_out.line_done   = 1'b1;
                        n_out.line_length = r_len;
                        n_out.last        = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= 6'd0;
            r_idx       <= 6'd0;
            r_len       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // read address follows the next index, so the data matches r_idx in ST_READ
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill] <= i_cmd.rx_byte;
        end
        r_rd_data <= r_mem[n_idx];
    end

    assign empty = !r_out_valid;
    assign o_res = r_out;

endmodule
`default_nettype wire
